@@ rtl/core/mmrs_pkg.sv @@
package mmrs_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic REQ_LOAD_B = 1'b0;
  localparam logic REQ_A_ELEM = 1'b1;

  typedef struct packed {
    logic                    is_a;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } back_state_e;

endpackage

@@ rtl/core/matrix_multiply_row_stream.sv @@
// Streams C = A x B for DIM x DIM matrices of signed Q1.15 elements with signed Q10.30
// 40-bit results. Load every B element first (req_type 0), then send A elements (req_type 1);
// an element whose row or column index is DIM or more is accepted and dropped. Transactions
// enter a two-entry queue, so in_ready_o stays high while the queue has room. A B load is
// written as it is taken. An A element holds the back end while its columns pass one per
// cycle, unless stalled, through a single 16x16 multiplier and one read and one write port
// of the accumulator memory, and while the read, multiply and add stages drain. The A
// element with column DIM-1 ends its row and emits DIM results, column 0 first, one per
// cycle while out_ready_i is high, with last_of_row_o on the final one; the accumulators
// then restart from zero. Reading a B entry that was never written gives an undefined value.
module matrix_multiply_row_stream #(
  parameter int unsigned DIM = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [mmrs_pkg::IDX_W-1:0]          row_index_i,
  input  logic [mmrs_pkg::IDX_W-1:0]          col_index_i,
  input  logic signed [mmrs_pkg::VAL_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mmrs_pkg::IDX_W-1:0]          c_row_o,
  output logic [mmrs_pkg::IDX_W-1:0]          c_col_o,
  output logic signed [mmrs_pkg::SUM_W-1:0]   c_value_o,
  output logic                                last_of_row_o
);
  import mmrs_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  mmrs_front #(
    .DIM(DIM)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_o       (push_cmd),
    .push_ready_i (push_ready)
  );

  mmrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_cmd)
  );

  mmrs_back #(
    .DIM(DIM)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_i         (pop_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .c_row_o       (c_row_o),
    .c_col_o       (c_col_o),
    .c_value_o     (c_value_o),
    .last_of_row_o (last_of_row_o)
  );

endmodule

@@ rtl/core/mmrs_front.sv @@
module mmrs_front #(
  parameter int unsigned DIM = 16
) (
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [mmrs_pkg::IDX_W-1:0]          row_index_i,
  input  logic [mmrs_pkg::IDX_W-1:0]          col_index_i,
  input  logic signed [mmrs_pkg::VAL_W-1:0]   value_i,
  output logic                                push_valid_o,
  output mmrs_pkg::cmd_t                      push_o,
  input  logic                                push_ready_i
);
  import mmrs_pkg::*;

  logic in_range;

  // out-of-range transactions are taken and dropped
  assign in_range = ({1'b0, row_index_i} < (IDX_W + 1)'(DIM)) &&
                    ({1'b0, col_index_i} < (IDX_W + 1)'(DIM));

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && in_range;

  always_comb begin
    push_o.is_a  = (req_type_i == REQ_A_ELEM);
    push_o.row   = row_index_i;
    push_o.col   = col_index_i;
    push_o.value = value_i;
    push_o.last  = (col_index_i == IDX_W'(DIM - 1));
  end

endmodule

@@ rtl/core/mmrs_queue.sv @@
module mmrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mmrs_pkg::cmd_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mmrs_pkg::cmd_t pop_o
);
  import mmrs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_o        = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

@@ rtl/core/mmrs_back.sv @@
module mmrs_back #(
  parameter int unsigned DIM = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  mmrs_pkg::cmd_t                      cmd_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mmrs_pkg::IDX_W-1:0]          c_row_o,
  output logic [mmrs_pkg::IDX_W-1:0]          c_col_o,
  output logic signed [mmrs_pkg::SUM_W-1:0]   c_value_o,
  output logic                                last_of_row_o
);
  import mmrs_pkg::*;

  localparam int unsigned NW = $clog2(DIM);
  localparam int unsigned AW = $clog2(DIM * DIM);

  back_state_e state_q, state_d;

  cmd_t                     cmd_q;
  logic [NW-1:0]            n_q, n_d;
  logic                     adv, issue, load_b, take_a;

  logic signed [VAL_W-1:0]  b_mem [DIM * DIM];
  logic signed [SUM_W-1:0]  acc_mem [DIM];
  logic [DIM-1:0]           acc_vld_q;

  logic [AW-1:0]            b_raddr, b_waddr;

  logic                     s1_vld_q;
  logic [NW-1:0]            s1_n_q;
  logic signed [VAL_W-1:0]  b_rd_q;
  logic signed [SUM_W-1:0]  acc_rd_q;
  logic                     accv_q;

  logic                     s2_vld_q;
  logic [NW-1:0]            s2_n_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum;

  logic                     out_vld_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [SUM_W-1:0]  out_val_q;
  logic                     out_last_q;

  assign adv     = !out_vld_q || out_ready_i;
  assign b_raddr = AW'(int'(cmd_q.col) * DIM + int'(n_q));
  assign b_waddr = AW'(int'(cmd_i.row) * DIM + int'(cmd_i.col));
  assign sum     = acc_q + SUM_W'(prod_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.is_a) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (adv && (n_q == NW'(DIM - 1))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      ST_IDLE:  cmd_ready_o = 1'b1;
      ST_ISSUE: issue = adv;
      ST_DRAIN: issue = 1'b0;
      default:  cmd_ready_o = 1'b0;
    endcase
  end

  assign load_b = cmd_valid_i && cmd_ready_o && !cmd_i.is_a;
  assign take_a = cmd_valid_i && cmd_ready_o && cmd_i.is_a;

  always_comb begin
    n_d = n_q;
    if (take_a) begin
      n_d = '0;
    end else if (issue) begin
      n_d = n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      if (adv) begin
        s1_vld_q  <= issue;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q && cmd_q.last;
        if (s2_vld_q) begin
          acc_vld_q[s2_n_q] <= !cmd_q.last;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_a) begin
      cmd_q <= cmd_i;
    end
  end

  // b store
  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_mem[b_waddr] <= cmd_i.value;
    end
    if (issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  // row accumulators, invalid entries read as zero
  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q && !cmd_q.last) begin
      acc_mem[s2_n_q] <= sum;
    end
    if (issue) begin
      acc_rd_q <= acc_mem[n_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_n_q <= n_q;
      accv_q <= acc_vld_q[n_q];
      s2_n_q <= s1_n_q;
      prod_q <= cmd_q.value * b_rd_q;
      acc_q  <= accv_q ? acc_rd_q : '0;
      if (s2_vld_q) begin
        out_row_q  <= cmd_q.row;
        out_col_q  <= IDX_W'(s2_n_q);
        out_val_q  <= sum;
        out_last_q <= (s2_n_q == NW'(DIM - 1));
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign c_row_o       = out_row_q;
  assign c_col_o       = out_col_q;
  assign c_value_o     = out_val_q;
  assign last_of_row_o = out_last_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_vld_q && !s2_vld_q))
    else $error("pipeline busy while back end idle");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> (out_col_q == IDX_W'(DIM - 1)))
    else $error("last result not on final column");

  a_issue_a_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> cmd_q.is_a)
    else $error("column pass for a non-A command");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_vld_q && cmd_q.last && (s2_n_q == NW'(DIM - 1))) |=> (acc_vld_q == '0))
    else $error("accumulators not cleared at row end");

endmodule

@@ tb/matrix_multiply_row_stream_test.sv @@
module matrix_multiply_row_stream_test;
  import mmrs_pkg::*;

  localparam int unsigned DIM = 16;
  localparam int unsigned TARGET_ITEMS = 430;
  localparam int unsigned HOLD_AT = 120;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4 * (DIM + 3);
  localparam int unsigned STEP_COUNT = 24;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } c_elem_t;

  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    bit                      known;
    logic signed [SUM_W-1:0] c_value;
  } step_row_t;

  typedef int int_q_t[$];

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    req_type_i;
  logic [IDX_W-1:0]        row_index_i;
  logic [IDX_W-1:0]        col_index_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [IDX_W-1:0]        c_row_o;
  logic [IDX_W-1:0]        c_col_o;
  logic signed [SUM_W-1:0] c_value_o;
  logic                    last_of_row_o;

  c_elem_t                 c_due [$];
  logic signed [VAL_W-1:0] b_mat [DIM][DIM];
  bit                      b_known [DIM][DIM];
  logic [SUM_W-1:0]        row_acc [DIM] = '{default: '0};
  int                      errors = 0;
  int                      items_sent = 0;
  bit                      steady = 1'b0;
  bit                      hold_done = 1'b0;

  // b row 15 all most negative, then row ends that read it
  step_row_t steps [STEP_COUNT] = '{
    '{REQ_LOAD_B, 6'd15, 6'd0,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd1,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd2,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd3,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd4,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd5,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd6,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd7,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd8,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd9,  16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd10, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd11, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd12, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd13, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd14, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd15, 16'sh8000, 1'b0, 40'sd0},
    '{REQ_A_ELEM, 6'd2,  6'd15, 16'sh8000, 1'b1, 40'sd1073741824},
    '{REQ_A_ELEM, 6'd63, 6'd15, 16'sh7fff, 1'b0, 40'sd0},
    '{REQ_A_ELEM, 6'd1,  6'd63, 16'sh0001, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd16, 6'd0,  16'sh7fff, 1'b0, 40'sd0},
    '{REQ_LOAD_B, 6'd15, 6'd63, 16'sh7fff, 1'b0, 40'sd0},
    '{REQ_A_ELEM, 6'd15, 6'd15, 16'sh7fff, 1'b1, -40'sd1073709056},
    '{REQ_A_ELEM, 6'd0,  6'd15, 16'sh0000, 1'b1, 40'sd0},
    '{REQ_A_ELEM, 6'd9,  6'd15, 16'sh8000, 1'b1, 40'sd1073741824}
  };

  matrix_multiply_row_stream #(
    .DIM(DIM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .c_row_o      (c_row_o),
    .c_col_o      (c_col_o),
    .c_value_o    (c_value_o),
    .last_of_row_o(last_of_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit b_row_ready(input int k);
    bit ok;
    ok = 1'b1;
    for (int n = 0; n < DIM; n++) begin
      ok &= b_known[k][n];
    end
    return ok;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      return 16'sh8000;
    end else if (sel < 10) begin
      return 16'sh7fff;
    end
    return VAL_W'($urandom);
  endfunction

  function automatic int_q_t shuffled(input int_q_t q);
    int j;
    int t;
    for (int i = q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  // load b, or multiply-accumulate an a element; emit the c row on its last column
  function automatic void matmul_step(input logic kind, input logic [IDX_W-1:0] row,
                                      input logic [IDX_W-1:0] col,
                                      input logic signed [VAL_W-1:0] value,
                                      input bit known, input logic signed [SUM_W-1:0] c_value);
    logic signed [PROD_W-1:0] prod;
    c_elem_t e;
    if (row >= DIM || col >= DIM) begin
      return;
    end
    if (kind == REQ_LOAD_B) begin
      b_mat[row][col] = value;
      b_known[row][col] = 1'b1;
      return;
    end
    for (int n = 0; n < DIM; n++) begin
      prod = value * b_mat[col][n];
      row_acc[n] = row_acc[n] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (col == DIM - 1) begin
      for (int n = 0; n < DIM; n++) begin
        e.row = row;
        e.col = IDX_W'(n);
        e.value = known ? c_value : row_acc[n];
        e.last = (n == DIM - 1);
        c_due.push_back(e);
        row_acc[n] = '0;
      end
    end
  endfunction

  task automatic offer(input logic kind, input logic [IDX_W-1:0] row,
                       input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] value,
                       input bit known, input logic signed [SUM_W-1:0] c_value);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    row_index_i <= row;
    col_index_i <= col;
    value_i     <= value;
    do @(posedge clk_i); while (!in_ready_o);
    matmul_step(kind, row, col, value, known, c_value);
    if (row < DIM && col < DIM) begin
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int_q_t ks;
    int     ready_rows;
    int     load_pct;
    int     pick;
    int     len;
    int     m;
    logic   kind;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_LOAD_B;
    row_index_i <= '0;
    col_index_i <= '0;
    value_i     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      offer(steps[i].kind, steps[i].row, steps[i].col, steps[i].value, steps[i].known,
            steps[i].c_value);
    end

    while (items_sent < TARGET_ITEMS) begin
      steady = (items_sent >= 200 && items_sent < 280);
      ready_rows = 0;
      for (int k = 0; k < DIM; k++) begin
        ready_rows += b_row_ready(k);
      end
      load_pct = (ready_rows < 6) ? 40 : 12;
      pick = $urandom_range(0, 99);
      if (pick < load_pct) begin
        // rewrite a full b row in random column order
        m = $urandom_range(0, DIM - 1);
        ks.delete();
        for (int k = 0; k < DIM; k++) begin
          ks.push_back(k);
        end
        ks = shuffled(ks);
        foreach (ks[i]) begin
          offer(REQ_LOAD_B, IDX_W'(m), IDX_W'(ks[i]), pick_value(), 1'b0, '0);
        end
      end else if (pick < load_pct + 10) begin
        kind = logic'($urandom_range(0, 1));
        r = IDX_W'($urandom_range(0, 63));
        c = IDX_W'($urandom_range(0, 63));
        if (kind == REQ_A_ELEM && r < DIM && c < DIM && !b_row_ready(c)) begin
          c[IDX_W-1] = 1'b1;
        end
        offer(kind, r, c, pick_value(), 1'b0, '0);
      end else begin
        ks.delete();
        for (int k = 0; k < DIM - 1; k++) begin
          if (b_row_ready(k)) begin
            ks.push_back(k);
          end
        end
        m = $urandom_range(0, DIM - 1);
        if ($urandom_range(0, 99) < 80) begin
          ks = shuffled(ks);
          foreach (ks[i]) begin
            offer(REQ_A_ELEM, IDX_W'(m), IDX_W'(ks[i]), pick_value(), 1'b0, '0);
          end
          offer(REQ_A_ELEM, IDX_W'(m), IDX_W'(DIM - 1), pick_value(), 1'b0, '0);
        end else begin
          // broken row: repeats, mixed rows, early ends
          ks.push_back(DIM - 1);
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) begin
            offer(REQ_A_ELEM, IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'(ks[$urandom_range(0, ks.size() - 1)]), pick_value(), 1'b0, '0);
          end
        end
      end
    end

    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (c_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS matrix_multiply_row_stream");
    end else begin
      $display("FAIL matrix_multiply_row_stream");
    end
    $finish;
  end

  initial begin : result_side
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_sent >= HOLD_AT) begin
        // long stall so the input side backs up
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin : c_check
    c_elem_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (c_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got row %0d col %0d value %0d",
                 $realtime, c_row_o, c_col_o, c_value_o);
      end else begin
        e = c_due.pop_front();
        if (c_row_o !== e.row) begin
          errors++;
          $display("%0t: c_row expected %0d got %0d", $realtime, e.row, c_row_o);
        end
        if (c_col_o !== e.col) begin
          errors++;
          $display("%0t: c_col expected %0d got %0d", $realtime, e.col, c_col_o);
        end
        if (c_value_o !== e.value) begin
          errors++;
          $display("%0t: c_value expected %0d got %0d", $realtime, e.value, c_value_o);
        end
        if (last_of_row_o !== e.last) begin
          errors++;
          $display("%0t: last_of_row expected %0b got %0b", $realtime, e.last, last_of_row_o);
        end
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("FAIL matrix_multiply_row_stream");
    $finish;
  end

endmodule
